// File: design/dlrc_pkg.sv
`default_nettype none
package dlrc_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int FIELD_W = 10;
    localparam int LEVEL_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W = 64;
    localparam int BIT_W = 6;
    localparam int ROW_WORDS_RAW = (MAX_NODES + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (ROW_WORDS_RAW > 1) ? $clog2(ROW_WORDS_RAW) : 1;
    localparam int T_W = WIDX_W + BIT_W;
    localparam int VIS_W = 2 ** T_W;
    localparam int EADDR_W = NODE_W + WIDX_W;
    localparam int EDGE_DEPTH = 2 ** EADDR_W;
    localparam int Q_DEPTH = 2 ** NODE_W;
    localparam int Q_W = NODE_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = CFG_IDX_W'(1);

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic edge_rd;
        logic edge_wr;
        logic q_init;
        logic lvl_start;
        logic node_pop;
        logic row_first;
        logic row_load;
        logic bit_take;
        logic row_next;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic start_ok;
        logic lvl_done;
        logic level_empty;
        logic pending_zero;
        logic last_word;
        logic out_busy;
    } sts_t;

endpackage
`default_nettype wire

// File: design/depth_limited_reach_count_core.sv
`default_nettype none
// Depth-limited reach counter. An edge word (mode 0) sets one bit of the adjacency
// matrix with a read-modify-write, reading the word and then writing it back; it
// gives no result. A query word (mode 1) walks breadth-first from the start node and
// returns one reach_count word. The matrix is held as 64-bit words in a single RAM, so
// a query reads every matrix word of each frontier node's row (16 words at 1024
// nodes), one word at a time. After reset the matrix is cleared one word a cycle
// (16384 words), during which no input word is taken; configuration writes are taken
// at any time and should be made while idle.
module depth_limited_reach_count_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic [dlrc_pkg::FIELD_W-1:0]      s_source_node,
    input  wire logic [dlrc_pkg::FIELD_W-1:0]      s_target_node,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [dlrc_pkg::FIELD_W-1:0]           m_reach_count,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dlrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dlrc_pkg::FIELD_W-1:0]      cfg_data
);
    import dlrc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    dlrc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dlrc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_source_node (s_source_node),
        .s_target_node (s_target_node),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reach_count (m_reach_count)
    );
endmodule
`default_nettype wire

// File: design/dlrc_ram.sv
`default_nettype none
module dlrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: design/dlrc_ctrl.sv
`default_nettype none
module dlrc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire logic          s_mode,
    output logic               s_ready,
    input  wire dlrc_pkg::sts_t sts,
    output dlrc_pkg::cmd_t     cmd
);
    import dlrc_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_EDGE_RD   = 4'd2;
    localparam logic [3:0] S_EDGE_WR   = 4'd3;
    localparam logic [3:0] S_Q_START   = 4'd4;
    localparam logic [3:0] S_LEVEL     = 4'd5;
    localparam logic [3:0] S_NODE      = 4'd6;
    localparam logic [3:0] S_NODE_WAIT = 4'd7;
    localparam logic [3:0] S_ROW_USE   = 4'd8;
    localparam logic [3:0] S_BITS      = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = (s_mode == MODE_QUERY) ? S_Q_START : S_EDGE_RD;
                end
            end
            S_EDGE_RD: begin
                cmd.edge_rd = 1'b1;
                state_next = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                cmd.edge_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_Q_START: begin
                cmd.q_init = 1'b1;
                state_next = sts.start_ok ? S_LEVEL : S_DONE;
            end
            S_LEVEL: begin
                if (sts.lvl_done) begin
                    state_next = S_DONE;
                end else begin
                    cmd.lvl_start = 1'b1;
                    state_next = S_NODE;
                end
            end
            S_NODE: begin
                if (sts.level_empty) begin
                    state_next = S_LEVEL;
                end else begin
                    cmd.node_pop = 1'b1;
                    state_next = S_NODE_WAIT;
                end
            end
            S_NODE_WAIT: begin
                cmd.row_first = 1'b1;
                state_next = S_ROW_USE;
            end
            S_ROW_USE: begin
                cmd.row_load = 1'b1;
                state_next = S_BITS;
            end
            S_BITS: begin
                if (!sts.pending_zero) begin
                    cmd.bit_take = 1'b1;
                end else if (sts.last_word) begin
                    state_next = S_NODE;
                end else begin
                    cmd.row_next = 1'b1;
                    state_next = S_ROW_USE;
                end
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

// File: design/dlrc_datapath.sv
`default_nettype none
module dlrc_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dlrc_pkg::cmd_t                    cmd,
    output dlrc_pkg::sts_t                         sts,
    input  wire logic                              s_mode,
    input  wire logic [dlrc_pkg::FIELD_W-1:0]      s_source_node,
    input  wire logic [dlrc_pkg::FIELD_W-1:0]      s_target_node,
    input  wire logic                              cfg_valid,
    input  wire logic [dlrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dlrc_pkg::FIELD_W-1:0]      cfg_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [dlrc_pkg::FIELD_W-1:0]           m_reach_count
);
    import dlrc_pkg::*;

    logic [FIELD_W-1:0] node_count_reg;
    logic [LEVEL_W-1:0] levels_reg;
    logic               mode_reg;
    logic [FIELD_W-1:0] src_reg, dst_reg;
    logic [EADDR_W-1:0] clr_addr_reg;
    logic [VIS_W-1:0]   visited_reg;
    logic [Q_W-1:0]     head_reg, tail_reg, level_end_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [NODE_W-1:0]  u_reg;
    logic [WIDX_W-1:0]  w_reg;
    logic [WORD_W-1:0]  pending_reg;
    logic [FIELD_W-1:0] count_reg;
    logic               m_valid_reg;
    logic [FIELD_W-1:0] result_reg;

    logic               e_we;
    logic [EADDR_W-1:0] e_waddr, e_raddr;
    logic [WORD_W-1:0]  e_wdata, e_rdata;
    logic               q_we;
    logic [NODE_W-1:0]  q_waddr, q_raddr;
    logic [NODE_W-1:0]  q_wdata, q_rdata;

    logic               src_ok, dst_ok, edge_ok;
    logic [T_W-1:0]     last;
    logic [T_W-1:0]     base;
    logic [T_W-1:0]     hi;
    logic [WORD_W-1:0]  range_mask;
    logic [WORD_W-1:0]  vis_word;
    logic [WORD_W-1:0]  iso;
    logic [BIT_W-1:0]   bit_idx;
    logic [T_W-1:0]     t_node;
    logic [T_W-1:0]     start_idx;

    assign src_ok = (src_reg != '0) && (int'(src_reg) < MAX_NODES);
    assign dst_ok = (dst_reg != '0) && (int'(dst_reg) < MAX_NODES);
    assign edge_ok = src_ok && dst_ok;
    assign start_idx = T_W'(src_reg);

    assign last = (int'(node_count_reg) < MAX_NODES) ? T_W'(node_count_reg)
                                                     : T_W'(MAX_NODES - 1);
    assign base = {w_reg, {BIT_W{1'b0}}};
    assign hi = last - base;
    assign vis_word = visited_reg[w_reg * WORD_W +: WORD_W];

    // Targets of this word that lie in 1..last.
    always_comb begin
        if (base > last) begin
            range_mask = '0;
        end else if (hi >= T_W'(WORD_W - 1)) begin
            range_mask = '1;
        end else begin
            range_mask = (WORD_W'(2) << hi[BIT_W-1:0]) - WORD_W'(1);
        end
        if (w_reg == '0) range_mask[0] = 1'b0;
    end

    // Lowest pending target is taken first, so each row's targets enter the queue in ascending order.
    assign iso = pending_reg & (~pending_reg + WORD_W'(1));
    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (iso[i]) bit_idx = bit_idx | BIT_W'(i);
        end
    end
    assign t_node = {w_reg, bit_idx};

    always_comb begin
        e_we = 1'b0;
        e_waddr = clr_addr_reg;
        e_wdata = '0;
        if (cmd.clr_wr) begin
            e_we = 1'b1;
        end else if (cmd.edge_wr && edge_ok) begin
            e_we = 1'b1;
            e_waddr = {NODE_W'(src_reg), WIDX_W'(dst_reg >> BIT_W)};
            e_wdata = e_rdata | (WORD_W'(1) << dst_reg[BIT_W-1:0]);
        end
    end

    always_comb begin
        if (cmd.row_first) begin
            e_raddr = {q_rdata, {WIDX_W{1'b0}}};
        end else if (cmd.row_next) begin
            e_raddr = {u_reg, w_reg + WIDX_W'(1)};
        end else begin
            e_raddr = {NODE_W'(src_reg), WIDX_W'(dst_reg >> BIT_W)};
        end
    end

    always_comb begin
        q_we = 1'b0;
        q_waddr = tail_reg[NODE_W-1:0];
        q_wdata = NODE_W'(t_node);
        if (cmd.q_init) begin
            q_we = src_ok;
            q_waddr = '0;
            q_wdata = NODE_W'(src_reg);
        end else if (cmd.bit_take && (int'(tail_reg) < MAX_NODES)) begin
            q_we = 1'b1;
        end
    end
    assign q_raddr = head_reg[NODE_W-1:0];

    dlrc_ram #(.WIDTH(WORD_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .clk   (aclk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    dlrc_ram #(.WIDTH(NODE_W), .DEPTH(Q_DEPTH)) u_queue_ram (
        .clk   (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= FIELD_W'(1023);
            levels_reg <= LEVEL_W'(3);
            clr_addr_reg <= '0;
            visited_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            level_end_reg <= '0;
            lvl_reg <= '0;
            count_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_NODE_COUNT) node_count_reg <= cfg_data;
                else if (cfg_index == CFG_LEVELS) levels_reg <= cfg_data[LEVEL_W-1:0];
            end
            if (cmd.clr_wr) clr_addr_reg <= clr_addr_reg + EADDR_W'(1);
            if (cmd.q_init) begin
                visited_reg <= src_ok ? (VIS_W'(1) << start_idx) : '0;
                head_reg <= '0;
                tail_reg <= Q_W'(1);
                lvl_reg <= '0;
                count_reg <= '0;
            end
            if (cmd.lvl_start) begin
                level_end_reg <= tail_reg;
                lvl_reg <= lvl_reg + LEVEL_W'(1);
            end
            if (cmd.node_pop) head_reg <= head_reg + Q_W'(1);
            if (cmd.bit_take) begin
                visited_reg[t_node] <= 1'b1;
                count_reg <= count_reg + FIELD_W'(1);
                if (int'(tail_reg) < MAX_NODES) tail_reg <= tail_reg + Q_W'(1);
            end
            if (cmd.res_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mode_reg <= s_mode;
            src_reg <= s_source_node;
            dst_reg <= s_target_node;
        end
        if (cmd.row_first) begin
            u_reg <= q_rdata;
            w_reg <= '0;
        end
        if (cmd.row_next) w_reg <= w_reg + WIDX_W'(1);
        if (cmd.row_load) pending_reg <= e_rdata & ~vis_word & range_mask;
        else if (cmd.bit_take) pending_reg <= pending_reg & ~iso;
        if (cmd.res_load) result_reg <= (mode_reg == MODE_QUERY) ? count_reg : '0;
    end

    assign sts.clr_done = &clr_addr_reg;
    assign sts.start_ok = src_ok;
    assign sts.lvl_done = (lvl_reg == levels_reg);
    assign sts.level_empty = (head_reg == level_end_reg);
    assign sts.pending_zero = (pending_reg == '0);
    assign sts.last_word = &w_reg;
    assign sts.out_busy = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_reach_count = result_reg;
endmodule
`default_nettype wire
